>>> rtl/rpn_pkg.sv
`default_nettype none
package rpn_pkg;

   localparam int DATA_W          = 32;
   localparam int CHAR_W          = 8;
   localparam int STATUS_W        = 3;
   localparam int STACK_DEPTH_DEF = 128;

   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_EQUALS = 8'h3D;
   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_OVERFLOW  = 3'd1,
      ST_UNDERFLOW = 3'd2,
      ST_LEFTOVER  = 3'd3,
      ST_NO_EQUALS = 3'd4,
      ST_DIV_ZERO  = 3'd5
   } status_type;

endpackage
`default_nettype wire

>>> rtl/rpn_ifs.sv
`default_nettype none
interface rpn_req_if;
   import rpn_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface rpn_rsp_if;
   import rpn_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, output result_value, output status, input ready);
   modport sink   (input valid, input result_value, input status, output ready);
endinterface
`default_nettype wire

>>> rtl/rpn_stack_mem.sv
`default_nettype none
module rpn_stack_mem #(
   parameter int DEPTH  = rpn_pkg::STACK_DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [rpn_pkg::DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [rpn_pkg::DATA_W-1:0] rd_data
);
   import rpn_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/rpn_divider.sv
`default_nettype none
module rpn_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rpn_pkg::DATA_W-1:0] dividend,
   input  logic [rpn_pkg::DATA_W-1:0] divisor,
   output logic                       done,
   output logic [rpn_pkg::DATA_W-1:0] quotient
);
   import rpn_pkg::*;

   localparam int CNT_W = $clog2(DATA_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] div_ff, div_in;
   logic [DATA_W:0]   trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      trial    = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, div_ff};
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(DATA_W);
         neg_in   = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         rem_in   = '0;
         quo_in   = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
         div_in   = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      neg_ff   <= neg_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;

endmodule
`default_nettype wire

>>> rtl/rpn_stack_evaluator.sv
// A digit is pushed as it is accepted; + - * go through S_READ_A and S_EXEC
// (read b, read a, write back); divide waits in S_DIV on the 32-step radix-2 loop.
// '=' goes through S_EQ to S_EMIT; a zero byte or other error goes to S_EMIT, which
// waits for a stalled response to drain. Requests are taken only in S_IDLE.
// Reset (synchronous, active high) empties the stack, clears discarding and the
// response valid; the stack memory itself is not cleared.
`default_nettype none
module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   rpn_req_if.sink    req_bus,
   rpn_rsp_if.source  rsp_bus
);
   import rpn_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam logic [LVL_W-1:0] DEPTH_L = LVL_W'(STACK_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_A,
      S_EXEC,
      S_DIV,
      S_EQ,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   state_type         state_ff, state_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic              discard_ff, discard_in;
   op_type            op_ff, op_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] pend_value_ff, pend_value_in;
   status_type        pend_status_ff, pend_status_in;
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   status_type        out_status_ff, out_status_in;

   logic              accept;
   logic [CHAR_W-1:0] ch;
   logic              is_digit;
   logic [LVL_W-1:0]  level_m1;
   logic [LVL_W-1:0]  level_m2;
   logic              fail;
   status_type        fail_code;
   logic [DATA_W-1:0] a_val;
   logic [DATA_W-1:0] mul_val;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic              div_start;
   logic              div_done;
   logic [DATA_W-1:0] div_quot;

   rpn_stack_mem #(
      .DEPTH  (STACK_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rpn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign ch            = req_bus.char_in;
   assign is_digit      = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign level_m1      = level_ff - LVL_W'(1);
   assign level_m2      = level_ff - LVL_W'(2);
   assign a_val         = rd_data;
   assign mul_val       = a_val * b_ff;

   always_comb begin
      state_in       = state_ff;
      level_in       = level_ff;
      discard_in     = discard_ff;
      op_in          = op_ff;
      b_in           = b_ff;
      pend_value_in  = pend_value_ff;
      pend_status_in = pend_status_ff;
      out_valid_in   = out_valid_ff;
      out_value_in   = out_value_ff;
      out_status_in  = out_status_ff;
      fail           = 1'b0;
      fail_code      = ST_OK;
      wr_en          = 1'b0;
      wr_addr        = level_ff[ADDR_W-1:0];
      wr_data        = '0;
      rd_addr        = level_m1[ADDR_W-1:0];
      div_start      = 1'b0;

      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (discard_ff) begin
                  if (ch == CH_EQUALS || ch == CH_NUL) begin
                     discard_in = 1'b0;
                     level_in   = '0;
                  end
               end else if (is_digit) begin
                  if (level_ff >= DEPTH_L) begin
                     fail      = 1'b1;
                     fail_code = ST_OVERFLOW;
                  end else begin
                     wr_en    = 1'b1;
                     wr_data  = DATA_W'(ch - CH_ZERO);
                     level_in = level_ff + LVL_W'(1);
                  end
               end else begin
                  case (ch) inside
                     CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
                        if (level_ff < LVL_W'(2)) begin
                           fail      = 1'b1;
                           fail_code = ST_UNDERFLOW;
                        end else begin
                           case (ch)
                              CH_PLUS:  op_in = OP_ADD;
                              CH_MINUS: op_in = OP_SUB;
                              CH_STAR:  op_in = OP_MUL;
                              default:  op_in = OP_DIV;
                           endcase
                           state_in = S_READ_A;
                        end
                     end
                     CH_EQUALS: begin
                        if (level_ff == '0) begin
                           fail      = 1'b1;
                           fail_code = ST_UNDERFLOW;
                        end else if (level_ff > LVL_W'(1)) begin
                           fail      = 1'b1;
                           fail_code = ST_LEFTOVER;
                        end else begin
                           rd_addr  = '0;
                           state_in = S_EQ;
                        end
                     end
                     CH_NUL: begin
                        fail      = 1'b1;
                        fail_code = ST_NO_EQUALS;
                     end
                     default: ;
                  endcase
               end
            end
         end
         S_READ_A: begin
            b_in     = rd_data;
            rd_addr  = level_m2[ADDR_W-1:0];
            state_in = S_EXEC;
         end
         S_EXEC: begin
            wr_addr = level_m2[ADDR_W-1:0];
            case (op_ff)
               OP_ADD: wr_data = a_val + b_ff;
               OP_SUB: wr_data = a_val - b_ff;
               OP_MUL: wr_data = mul_val;
               default: wr_data = '0;
            endcase
            if (op_ff == OP_DIV) begin
               if (b_ff == '0) begin
                  fail      = 1'b1;
                  fail_code = ST_DIV_ZERO;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end else begin
               wr_en    = 1'b1;
               level_in = level_m1;
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            wr_addr = level_m2[ADDR_W-1:0];
            wr_data = div_quot;
            if (div_done) begin
               wr_en    = 1'b1;
               level_in = level_m1;
               state_in = S_IDLE;
            end
         end
         S_EQ: begin
            pend_value_in  = rd_data;
            pend_status_in = ST_OK;
            level_in       = '0;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in  = 1'b1;
               out_value_in  = pend_value_ff;
               out_status_in = pend_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (fail) begin
         pend_value_in  = '0;
         pend_status_in = fail_code;
         discard_in     = 1'b1;
         level_in       = '0;
         state_in       = S_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      b_ff           <= b_in;
      pend_value_ff  <= pend_value_in;
      pend_status_ff <= pend_status_in;
      out_value_ff   <= out_value_in;
      out_status_ff  <= out_status_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         discard_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         discard_ff   <= discard_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.result_value = $signed(out_value_ff);
   assign rsp_bus.status       = out_status_ff;

endmodule
`default_nettype wire

>>> rtl/rpn_checker.sv
`default_nettype none
module rpn_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rpn_pkg::DATA_W-1:0] rsp_result_value,
   input logic [rpn_pkg::STATUS_W-1:0] rsp_status
);
   import rpn_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_status))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_value == '0)
      else $error("error response carries a nonzero value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_DIV_ZERO)
      else $error("unknown status code");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response rose in the cycle after a request");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_result_value (rsp_bus.result_value),
   .rsp_status       (rsp_bus.status)
);
`default_nettype wire
